@@ sv/mps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mps_pkg;

  localparam int MAX_STIM_DEF     = 4;
  localparam int MAX_CHANNELS_DEF = 256;
  localparam int SAMPLE_BITS_DEF  = 24;

  localparam int CHAN_W      = 8;
  localparam int FRAME_W     = 32;
  localparam int TYPE_OUT_W  = 2;
  localparam int STIM_CNT_W  = 3;
  localparam int OUT_TDATA_W = 72;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_MARKER_REGS = 4;

  localparam logic [REG_IDX_W-1:0] REG_STIM_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MARKER_A   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MARKER_B   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MARKER_C   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MARKER_D   = 3'd4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_END    = 1'b1;

  typedef enum logic [1:0] {
    KIND_PULSE = 2'd0,
    KIND_NONE  = 2'd1,
    KIND_NEG   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [FRAME_W-1:0]      pulse_first;
    logic [FRAME_W-1:0]      pulse_last;
    logic [TYPE_OUT_W-1:0]   stim_type;
    logic                    overlap;
  } res_t;

endpackage

`default_nettype wire

@@ sv/mps_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mps_cfg
  import mps_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output logic      [STIM_CNT_W-1:0]  stim_count,
  output logic [NUM_MARKER_REGS-1:0][CHAN_W-1:0] marker_chan
);

  logic [STIM_CNT_W-1:0] stim_count_r;
  logic [NUM_MARKER_REGS-1:0][CHAN_W-1:0] marker_r;
  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stim_count_r <= STIM_CNT_W'(1);
      for (int k = 0; k < NUM_MARKER_REGS; k++) begin
        marker_r[k] <= CHAN_W'(k);
      end
    end else if (wr) begin
      if (idx == REG_STIM_COUNT) begin
        stim_count_r <= cfg_pwdata[STIM_CNT_W-1:0];
      end
      for (int k = 0; k < NUM_MARKER_REGS; k++) begin
        if (idx == REG_MARKER_A + REG_IDX_W'(k)) begin
          marker_r[k] <= cfg_pwdata[CHAN_W-1:0];
        end
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_STIM_COUNT: cfg_prdata = CFG_DATA_W'(stim_count_r);
      REG_MARKER_A:   cfg_prdata = CFG_DATA_W'(marker_r[0]);
      REG_MARKER_B:   cfg_prdata = CFG_DATA_W'(marker_r[1]);
      REG_MARKER_C:   cfg_prdata = CFG_DATA_W'(marker_r[2]);
      REG_MARKER_D:   cfg_prdata = CFG_DATA_W'(marker_r[3]);
      default:        cfg_prdata = '0;
    endcase
  end

  assign stim_count  = stim_count_r;
  assign marker_chan = marker_r;

endmodule

`default_nettype wire

@@ sv/mps_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mps_core
  import mps_pkg::*;
#(
  parameter int MAX_STIM     = MAX_STIM_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic                          op,
  input  wire logic [CHAN_W-1:0]             chan,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          fend,
  input  wire logic [STIM_CNT_W-1:0]         stim_count,
  input  wire logic [MAX_STIM-1:0][CHAN_W-1:0] marker_chan,
  input  wire logic                          res_take,
  output logic                               res_valid,
  output res_t                               res
);

  localparam int STW = (MAX_STIM > 1) ? $clog2(MAX_STIM) : 1;

  logic [FRAME_W-1:0]  frame_count_r, frame_count_nxt;
  logic                in_pulse_r, in_pulse_nxt;
  logic [FRAME_W-1:0]  start_frame_r, start_frame_nxt;
  logic [STW-1:0]      active_type_r, active_type_nxt;
  logic [MAX_STIM-1:0] up_mask_r, up_mask_nxt;
  logic                start_overlap_r, start_overlap_nxt;
  logic                neg_seen_r, neg_seen_nxt;
  logic                res_valid_r, res_valid_nxt;
  res_t                res_r, res_nxt;

  logic [MAX_STIM-1:0] hit;
  logic [MAX_STIM-1:0] up_now;
  logic                neg_now;
  logic                pos, neg;
  logic [STW-1:0]      low_type;
  logic                multi;
  logic                produce;
  logic                chan_ok;

  assign neg     = sample[SAMPLE_BITS-1];
  assign pos     = !sample[SAMPLE_BITS-1] && (|sample);
  assign chan_ok = (32'(chan) < MAX_CHANNELS);

  always_comb begin
    for (int r = 0; r < MAX_STIM; r++) begin
      hit[r] = chan_ok && (r < int'(stim_count)) && (marker_chan[r] == chan);
    end
  end

  assign up_now  = up_mask_r | (hit & {MAX_STIM{pos}});
  assign neg_now = neg_seen_r || ((|hit) && neg);
  // more than one bit set
  assign multi   = |(up_now & (up_now - MAX_STIM'(1)));

  always_comb begin
    low_type = '0;
    for (int r = MAX_STIM - 1; r >= 0; r--) begin
      if (up_now[r]) begin
        low_type = STW'(r);
      end
    end
  end

  always_comb begin
    frame_count_nxt   = frame_count_r;
    in_pulse_nxt      = in_pulse_r;
    start_frame_nxt   = start_frame_r;
    active_type_nxt   = active_type_r;
    up_mask_nxt       = up_mask_r;
    start_overlap_nxt = start_overlap_r;
    neg_seen_nxt      = neg_seen_r;
    res_nxt           = res_r;
    produce           = 1'b0;

    if (step) begin
      if (op == OP_END) begin
        produce = 1'b1;
        if (in_pulse_r) begin
          res_nxt.kind        = KIND_PULSE;
          res_nxt.pulse_first = start_frame_r;
          res_nxt.pulse_last  = frame_count_r - FRAME_W'(1);
          res_nxt.stim_type   = TYPE_OUT_W'(active_type_r);
          res_nxt.overlap     = start_overlap_r;
        end else begin
          res_nxt = '{kind: KIND_NONE, default: '0};
        end
        in_pulse_nxt = 1'b0;
        up_mask_nxt  = '0;
        neg_seen_nxt = 1'b0;
      end else if (!fend) begin
        up_mask_nxt  = up_now;
        neg_seen_nxt = neg_now;
      end else begin
        up_mask_nxt     = '0;
        neg_seen_nxt    = 1'b0;
        frame_count_nxt = frame_count_r + FRAME_W'(1);
        if (in_pulse_r) begin
          if (!up_now[active_type_r]) begin
            produce      = 1'b1;
            in_pulse_nxt = 1'b0;
            if (neg_now) begin
              res_nxt             = '{kind: KIND_NEG, default: '0};
              res_nxt.pulse_first = frame_count_r;
            end else begin
              res_nxt.kind        = KIND_PULSE;
              res_nxt.pulse_first = start_frame_r;
              res_nxt.pulse_last  = frame_count_r - FRAME_W'(1);
              res_nxt.stim_type   = TYPE_OUT_W'(active_type_r);
              res_nxt.overlap     = start_overlap_r;
              // the closing frame may open the next pulse
              if (|up_now) begin
                in_pulse_nxt      = 1'b1;
                start_frame_nxt   = frame_count_r;
                active_type_nxt   = low_type;
                start_overlap_nxt = multi;
              end
            end
          end
        end else if (neg_now) begin
          produce             = 1'b1;
          res_nxt             = '{kind: KIND_NEG, default: '0};
          res_nxt.pulse_first = frame_count_r;
        end else if (|up_now) begin
          in_pulse_nxt      = 1'b1;
          start_frame_nxt   = frame_count_r;
          active_type_nxt   = low_type;
          start_overlap_nxt = multi;
        end
      end
    end

    res_valid_nxt = res_valid_r;
    if (res_take) begin
      res_valid_nxt = 1'b0;
    end
    if (produce) begin
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r   <= '0;
      in_pulse_r      <= 1'b0;
      start_frame_r   <= '0;
      active_type_r   <= '0;
      up_mask_r       <= '0;
      start_overlap_r <= 1'b0;
      neg_seen_r      <= 1'b0;
      res_valid_r     <= 1'b0;
    end else begin
      frame_count_r   <= frame_count_nxt;
      in_pulse_r      <= in_pulse_nxt;
      start_frame_r   <= start_frame_nxt;
      active_type_r   <= active_type_nxt;
      up_mask_r       <= up_mask_nxt;
      start_overlap_r <= start_overlap_nxt;
      neg_seen_r      <= neg_seen_nxt;
      res_valid_r     <= res_valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

@@ sv/marker_pulse_segmenter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// An accepted request reaches its result through the input register, then the result register.
// Throughput: one request per cycle; a held result stalls the input only when the
// input register is also full.
// Reset (rst_n low, synchronous): clears frame count, pulse state and both valid flags;
// configuration returns to stim_count 1 and marker channels 0..3.
module marker_pulse_segmenter
  import mps_pkg::*;
#(
  parameter int MAX_STIM     = MAX_STIM_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // chan [7:0], sample [8+SAMPLE_BITS-1:8], zero pad
  input  wire logic [((CHAN_W+SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  wire logic                    in_tuser,   // op
  input  wire logic                    in_tlast,   // frame_end
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // pulse_first [31:0], pulse_last [63:32], stim_type [65:64], overlap [66], zero pad
  output logic [OUT_TDATA_W-1:0]       out_tdata,
  output logic [1:0]                   out_tuser,  // kind
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [CFG_DATA_W-1:0]        cfg_prdata,
  output logic                         cfg_pready
);

  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_op_r;
  logic [CHAN_W-1:0]             s1_chan_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          s1_fend_r;
  logic                          step;
  logic                          in_acc;
  logic                          res_valid;
  res_t                          res;

  logic [STIM_CNT_W-1:0]                  stim_count;
  logic [NUM_MARKER_REGS-1:0][CHAN_W-1:0] cfg_marker;
  logic [MAX_STIM-1:0][CHAN_W-1:0]        marker_chan;

  mps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .stim_count  (stim_count),
    .marker_chan (cfg_marker)
  );

  // types beyond the programmable ones keep their fixed channel
  for (genvar r = 0; r < MAX_STIM; r++) begin : g_mchan
    if (r < NUM_MARKER_REGS) begin : g_reg
      assign marker_chan[r] = cfg_marker[r];
    end else begin : g_fix
      assign marker_chan[r] = CHAN_W'(r);
    end
  end

  // the input register moves on when the result register is free or draining
  assign step      = s1_valid_r && (!res_valid || out_tready);
  assign in_tready = !s1_valid_r || step;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (step) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_acc) begin
      s1_op_r     <= in_tuser;
      s1_chan_r   <= in_tdata[CHAN_W-1:0];
      s1_sample_r <= in_tdata[CHAN_W +: SAMPLE_BITS];
      s1_fend_r   <= in_tlast;
    end
  end

  mps_core #(
    .MAX_STIM     (MAX_STIM),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .op          (s1_op_r),
    .chan        (s1_chan_r),
    .sample      (s1_sample_r),
    .fend        (s1_fend_r),
    .stim_count  (stim_count),
    .marker_chan (marker_chan),
    .res_take    (out_tready),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign out_tvalid = res_valid;
  assign out_tuser  = res.kind;
  assign out_tdata  = OUT_TDATA_W'({res.overlap, res.stim_type, res.pulse_last,
                                    res.pulse_first});

endmodule

`default_nettype wire

@@ sv/mps_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mps_checker
  import mps_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic [((CHAN_W+SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [1:0]            out_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // input stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  a_reset_clear: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_NONE |-> out_tdata == '0)
    else $error("no-pulse report carries data");

  // a waiting request is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("request changed while stalled");

endmodule

bind marker_pulse_segmenter mps_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
